[hdl/cprj_pkg.sv]
`default_nettype none
// Shared types, widths and helpers for the plane residual / Jacobian pipeline.
package cprj_pkg;

  localparam int unsigned NUM_AXES = 3;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned WIDE_W   = 64;
  // |q| < 2^34 and |u| <= 2^24 for every legal input and FRAC_BITS
  localparam int unsigned MAG_Q_W  = 35;
  localparam int unsigned MAG_U_W  = 25;
  localparam int unsigned SGN_W    = WIDE_W + 1;
  localparam int unsigned SUM_W    = SGN_W + 2;
  localparam int unsigned DIVA_LANES = 1 + 2 * NUM_AXES;

  typedef logic [WORD_W-1:0]        word_t;
  typedef logic [WIDE_W-1:0]        wide_t;
  typedef logic signed [SGN_W-1:0]  sval_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  // travels beside the square root
  typedef struct packed {
    wide_t                       dmag;
    logic                        dneg;
    logic [NUM_AXES-1:0][WORD_W-1:0] cm;
    logic [NUM_AXES-1:0][WORD_W-1:0] pm;
    logic [NUM_AXES-1:0]         cn;
    logic [NUM_AXES-1:0]         pn;
    logic                        degen;
  } tag_s_t;

  // travels beside the first divider bank
  typedef struct packed {
    word_t               n;
    logic                dneg;
    logic [NUM_AXES-1:0] cn;
    logic [NUM_AXES-1:0] pn;
    logic                degen;
  } tag_a_t;

  // travels beside the second divider bank
  typedef struct packed {
    word_t                          n;
    sval_t                          q;
    logic [NUM_AXES-1:0][SGN_W-1:0] t1;
    logic [NUM_AXES-1:0][SGN_W-1:0] u;
    logic [NUM_AXES-1:0]            qun;
    logic                           degen;
  } tag_b_t;

  function automatic sval_t to_sval(input wide_t mag, input logic neg);
    sval_t v;
    v = $signed({1'b0, mag});
    return neg ? -v : v;
  endfunction

  function automatic word_t sat32(input sum_t v);
    word_t r;
    if ((&v[SUM_W-1:WORD_W-1]) || !(|v[SUM_W-1:WORD_W-1])) begin
      r = v[WORD_W-1:0];
    end else if (v[SUM_W-1]) begin
      r = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(WORD_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[hdl/cprj_isqrt.sv]
`default_nettype none
// Pipelined integer square root, one result bit per stage, with a side tag.
module cprj_isqrt #(
  parameter int unsigned X_W   = 64,
  parameter int unsigned TAG_W = 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  logic [X_W-1:0]     in_x,
  input  logic [TAG_W-1:0]   in_tag,
  output logic               out_vld,
  output logic [X_W/2-1:0]   out_root,
  output logic [TAG_W-1:0]   out_tag
);

  localparam int unsigned NS  = X_W / 2;
  localparam int unsigned M_W = NS + 1;

  logic             vld_r  [NS];
  logic [M_W-1:0]   rem_r  [NS];
  logic [NS-1:0]    root_r [NS];
  logic [X_W-1:0]   x_r    [NS];
  logic [TAG_W-1:0] tag_r  [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stg
    logic             pv;
    logic [M_W-1:0]   prem;
    logic [NS-1:0]    proot;
    logic [X_W-1:0]   px;
    logic [TAG_W-1:0] pt;
    logic [M_W+1:0]   sh;
    logic [M_W+1:0]   trial;
    logic [M_W+1:0]   diff;
    logic             ge;
    logic [M_W-1:0]   rem_nxt;
    logic [NS-1:0]    root_nxt;

    if (k == 0) begin : g_first
      assign pv    = in_vld;
      assign prem  = '0;
      assign proot = '0;
      assign px    = in_x;
      assign pt    = in_tag;
    end else begin : g_next
      assign pv    = vld_r[k-1];
      assign prem  = rem_r[k-1];
      assign proot = root_r[k-1];
      assign px    = x_r[k-1];
      assign pt    = tag_r[k-1];
    end

    assign sh       = {prem, px[X_W-1 -: 2]};
    assign trial    = {1'b0, proot, 2'b01};
    assign diff     = sh - trial;
    assign ge       = sh >= trial;
    assign rem_nxt  = ge ? diff[M_W-1:0] : sh[M_W-1:0];
    assign root_nxt = {proot[NS-2:0], ge};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        x_r[k]    <= {px[X_W-3:0], 2'b00};
        tag_r[k]  <= pt;
      end
    end
  end

  assign out_vld  = vld_r[NS-1];
  assign out_root = root_r[NS-1];
  assign out_tag  = tag_r[NS-1];

endmodule
`default_nettype wire

[hdl/cprj_div.sv]
`default_nettype none
// Pipelined restoring divider bank: lanes share one divisor, one quotient bit per stage.
module cprj_div #(
  parameter int unsigned LANES = 1,
  parameter int unsigned W     = 64,
  parameter int unsigned D_W   = 32,
  parameter int unsigned TAG_W = 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_vld,
  input  logic [LANES-1:0][W-1:0]     in_den,
  input  logic [D_W-1:0]              in_dsr,
  input  logic [TAG_W-1:0]            in_tag,
  output logic                        out_vld,
  output logic [LANES-1:0][W-1:0]     out_quo,
  output logic [TAG_W-1:0]            out_tag
);

  logic                        vld_r [W];
  logic [D_W-1:0]              dsr_r [W];
  logic [TAG_W-1:0]            tag_r [W];
  logic [LANES-1:0][D_W-1:0]   rem_r [W];
  logic [LANES-1:0][W-1:0]     dq_r  [W];

  for (genvar k = 0; k < W; k++) begin : g_stg
    logic                      pv;
    logic [D_W-1:0]            pd;
    logic [TAG_W-1:0]          pt;
    logic [LANES-1:0][D_W-1:0] prem;
    logic [LANES-1:0][W-1:0]   pdq;
    logic [LANES-1:0][D_W-1:0] rem_nxt;
    logic [LANES-1:0][W-1:0]   dq_nxt;

    if (k == 0) begin : g_first
      assign pv   = in_vld;
      assign pd   = in_dsr;
      assign pt   = in_tag;
      assign prem = '0;
      assign pdq  = in_den;
    end else begin : g_next
      assign pv   = vld_r[k-1];
      assign pd   = dsr_r[k-1];
      assign pt   = tag_r[k-1];
      assign prem = rem_r[k-1];
      assign pdq  = dq_r[k-1];
    end

    always_comb begin
      logic [D_W:0] sh;
      logic [D_W:0] diff;
      logic         ge;
      for (int l = 0; l < LANES; l++) begin
        sh          = {prem[l], pdq[l][W-1]};
        diff        = sh - {1'b0, pd};
        ge          = sh >= {1'b0, pd};
        rem_nxt[l]  = ge ? diff[D_W-1:0] : sh[D_W-1:0];
        dq_nxt[l]   = {pdq[l][W-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dsr_r[k] <= pd;
        tag_r[k] <= pt;
        rem_r[k] <= rem_nxt;
        dq_r[k]  <= dq_nxt;
      end
    end
  end

  assign out_vld = vld_r[W-1];
  assign out_quo = dq_r[W-1];
  assign out_tag = tag_r[W-1];

endmodule
`default_nettype wire

[hdl/cp_plane_residual_jacobian_core.sv]
`default_nettype none
// Top level: point-to-plane residual and Jacobian for a closest-point plane, fully pipelined.
//
//  channel | signals                                   | dir | transfer when
//  --------+-------------------------------------------+-----+-------------------------
//  in      | in_plane_c{x,y,z}, in_point_{x,y,z}       | in  | in_valid & in_ready
//  out     | out_residual, out_jac_c{x,y,z}, out_degen. | out | out_valid & out_ready
//
//  One transfer per cycle in steady state, unless out_ready stalls it; the path from input
//  transfer to output valid is 3 front stages (multiply, sum, dot-product sign),
//  32 square-root stages, 64 divider stages, 1 multiply stage, 64 divider
//  stages, 1 sign stage and the output register.
//  Latency is set by the bit-per-stage square root and the two divider banks.
//  Synchronous active-low reset clears all valid bits; payload is not reset.
//  A stall on out_ready freezes every stage at once (global enable); nothing
//  is dropped or duplicated, and in_ready drops only while the output is full.
module cp_plane_residual_jacobian_core #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [cprj_pkg::WORD_W-1:0]   in_plane_cx,
  input  logic [cprj_pkg::WORD_W-1:0]   in_plane_cy,
  input  logic [cprj_pkg::WORD_W-1:0]   in_plane_cz,
  input  logic [cprj_pkg::WORD_W-1:0]   in_point_x,
  input  logic [cprj_pkg::WORD_W-1:0]   in_point_y,
  input  logic [cprj_pkg::WORD_W-1:0]   in_point_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cprj_pkg::WORD_W-1:0]   out_residual,
  output logic [cprj_pkg::WORD_W-1:0]   out_jac_cx,
  output logic [cprj_pkg::WORD_W-1:0]   out_jac_cy,
  output logic [cprj_pkg::WORD_W-1:0]   out_jac_cz,
  output logic                          out_degenerate
);

  import cprj_pkg::*;

  // global pipeline enable: advance unless the output register is full and stalled
  logic en;
  logic out_valid_r;
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // ---------------- stage 1: magnitudes and 32x32 products ----------------
  logic [NUM_AXES-1:0][WORD_W-1:0] c_in, p_in;
  logic [NUM_AXES-1:0][WORD_W-1:0] cm_nxt, pm_nxt;
  logic [NUM_AXES-1:0][WIDE_W-1:0] sq_nxt, pr_nxt;
  logic [NUM_AXES-1:0]             cn_nxt, pn_nxt;

  assign c_in = {in_plane_cz, in_plane_cy, in_plane_cx};
  assign p_in = {in_point_z, in_point_y, in_point_x};

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      cn_nxt[i] = c_in[i][WORD_W-1];
      pn_nxt[i] = p_in[i][WORD_W-1];
      cm_nxt[i] = cn_nxt[i] ? (~c_in[i]) + word_t'(1) : c_in[i];
      pm_nxt[i] = pn_nxt[i] ? (~p_in[i]) + word_t'(1) : p_in[i];
      sq_nxt[i] = cm_nxt[i] * cm_nxt[i];
      pr_nxt[i] = cm_nxt[i] * pm_nxt[i];
    end
  end

  logic                            s1_v_r;
  logic [NUM_AXES-1:0][WIDE_W-1:0] s1_sq_r, s1_pr_r;
  logic [NUM_AXES-1:0][WORD_W-1:0] s1_cm_r, s1_pm_r;
  logic [NUM_AXES-1:0]             s1_cn_r, s1_pn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sq_r <= sq_nxt;
      s1_pr_r <= pr_nxt;
      s1_cm_r <= cm_nxt;
      s1_pm_r <= pm_nxt;
      s1_cn_r <= cn_nxt;
      s1_pn_r <= pn_nxt;
    end
  end

  // ---------------- stage 2: sum of squares, split dot product ----------------
  wide_t sumsq_nxt, pos_nxt, neg_nxt;

  always_comb begin
    sumsq_nxt = s1_sq_r[0] + s1_sq_r[1] + s1_sq_r[2];
    pos_nxt   = '0;
    neg_nxt   = '0;
    for (int i = 0; i < NUM_AXES; i++) begin
      // product sign is the xor of the operand signs
      if (s1_cn_r[i] != s1_pn_r[i]) begin
        neg_nxt = neg_nxt + s1_pr_r[i];
      end else begin
        pos_nxt = pos_nxt + s1_pr_r[i];
      end
    end
  end

  logic                            s2_v_r;
  wide_t                           s2_sumsq_r, s2_pos_r, s2_neg_r;
  logic [NUM_AXES-1:0][WORD_W-1:0] s2_cm_r, s2_pm_r;
  logic [NUM_AXES-1:0]             s2_cn_r, s2_pn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_sumsq_r <= sumsq_nxt;
      s2_pos_r   <= pos_nxt;
      s2_neg_r   <= neg_nxt;
      s2_cm_r    <= s1_cm_r;
      s2_pm_r    <= s1_pm_r;
      s2_cn_r    <= s1_cn_r;
      s2_pn_r    <= s1_pn_r;
    end
  end

  // ---------------- stage 3: dot product sign/magnitude, zero check ----------------
  tag_s_t s3_tag_nxt;
  logic   dneg;

  assign dneg = s2_neg_r > s2_pos_r;

  always_comb begin
    s3_tag_nxt.dneg  = dneg;
    s3_tag_nxt.dmag  = dneg ? s2_neg_r - s2_pos_r : s2_pos_r - s2_neg_r;
    s3_tag_nxt.cm    = s2_cm_r;
    s3_tag_nxt.pm    = s2_pm_r;
    s3_tag_nxt.cn    = s2_cn_r;
    s3_tag_nxt.pn    = s2_pn_r;
    s3_tag_nxt.degen = (s2_sumsq_r == '0);
  end

  logic   s3_v_r;
  wide_t  s3_sumsq_r;
  tag_s_t s3_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_sumsq_r <= s2_sumsq_r;
      s3_tag_r   <= s3_tag_nxt;
    end
  end

  // ---------------- norm: n = floor(sqrt(sumsq)) ----------------
  logic   sq_v;
  word_t  sq_n;
  tag_s_t sq_tag;

  cprj_isqrt #(
    .X_W   (WIDE_W),
    .TAG_W ($bits(tag_s_t))
  ) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (s3_v_r),
    .in_x     (s3_sumsq_r),
    .in_tag   (s3_tag_r),
    .out_vld  (sq_v),
    .out_root (sq_n),
    .out_tag  (sq_tag)
  );

  // ---------------- divider bank A: q, u_i, t1_i (all over n) ----------------
  // lane 0: |D|, lanes 1..3: |c_i| << F, lanes 4..6: |p_i| << F
  logic [DIVA_LANES-1:0][WIDE_W-1:0] da_den;
  tag_a_t                            da_tag_in;

  always_comb begin
    da_den[0] = sq_tag.dmag;
    for (int i = 0; i < NUM_AXES; i++) begin
      da_den[1+i]          = wide_t'(sq_tag.cm[i]) << FRAC_BITS;
      da_den[1+NUM_AXES+i] = wide_t'(sq_tag.pm[i]) << FRAC_BITS;
    end
    da_tag_in.n     = sq_n;
    da_tag_in.dneg  = sq_tag.dneg;
    da_tag_in.cn    = sq_tag.cn;
    da_tag_in.pn    = sq_tag.pn;
    da_tag_in.degen = sq_tag.degen;
  end

  logic                              da_v;
  logic [DIVA_LANES-1:0][WIDE_W-1:0] da_quo;
  tag_a_t                            da_tag;

  cprj_div #(
    .LANES (DIVA_LANES),
    .W     (WIDE_W),
    .D_W   (WORD_W),
    .TAG_W ($bits(tag_a_t))
  ) u_div_a (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (sq_v),
    .in_den  (da_den),
    .in_dsr  (sq_n),
    .in_tag  (da_tag_in),
    .out_vld (da_v),
    .out_quo (da_quo),
    .out_tag (da_tag)
  );

  // ---------------- stage B: unsigned q*u_i products, signed q, u_i, t1_i ----------------
  logic [NUM_AXES-1:0][WIDE_W-1:0] qu_nxt;
  tag_b_t                          sb_tag_nxt;

  always_comb begin
    sb_tag_nxt.n     = da_tag.n;
    sb_tag_nxt.q     = to_sval(da_quo[0], da_tag.dneg);
    sb_tag_nxt.degen = da_tag.degen;
    for (int i = 0; i < NUM_AXES; i++) begin
      qu_nxt[i]         = da_quo[0][MAG_Q_W-1:0] * da_quo[1+i][MAG_U_W-1:0];
      sb_tag_nxt.u[i]   = to_sval(da_quo[1+i], da_tag.cn[i]);
      sb_tag_nxt.t1[i]  = to_sval(da_quo[1+NUM_AXES+i], da_tag.pn[i]);
      sb_tag_nxt.qun[i] = da_tag.dneg ^ da_tag.cn[i];
    end
  end

  logic                            sb_v_r;
  logic [NUM_AXES-1:0][WIDE_W-1:0] sb_qu_r;
  tag_b_t                          sb_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_v_r <= 1'b0;
    end else if (en) begin
      sb_v_r <= da_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_qu_r  <= qu_nxt;
      sb_tag_r <= sb_tag_nxt;
    end
  end

  // ---------------- divider bank B: t2_i = q*u_i / n ----------------
  logic                            db_v;
  logic [NUM_AXES-1:0][WIDE_W-1:0] db_quo;
  tag_b_t                          db_tag;

  cprj_div #(
    .LANES (NUM_AXES),
    .W     (WIDE_W),
    .D_W   (WORD_W),
    .TAG_W ($bits(tag_b_t))
  ) u_div_b (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (sb_v_r),
    .in_den  (sb_qu_r),
    .in_dsr  (sb_tag_r.n),
    .in_tag  (sb_tag_r),
    .out_vld (db_v),
    .out_quo (db_quo),
    .out_tag (db_tag)
  );

  // ---------------- stage F: apply sign to t2 ----------------
  logic [NUM_AXES-1:0][SGN_W-1:0] t2_nxt;

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      t2_nxt[i] = to_sval(db_quo[i], db_tag.qun[i]);
    end
  end

  logic                           sf_v_r;
  logic [NUM_AXES-1:0][SGN_W-1:0] sf_t2_r;
  tag_b_t                         sf_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sf_v_r <= 1'b0;
    end else if (en) begin
      sf_v_r <= db_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sf_t2_r  <= t2_nxt;
      sf_tag_r <= db_tag;
    end
  end

  // ---------------- output: combine, saturate, zero on degenerate ----------------
  word_t                           res_nxt;
  logic [NUM_AXES-1:0][WORD_W-1:0] jac_nxt;

  always_comb begin
    sum_t q_w, n_w, t1_w, t2_w, u_w;
    q_w     = $signed(sf_tag_r.q);
    n_w     = $signed({1'b0, sf_tag_r.n});
    res_nxt = sf_tag_r.degen ? '0 : sat32(q_w - n_w);
    for (int i = 0; i < NUM_AXES; i++) begin
      t1_w       = $signed(sf_tag_r.t1[i]);
      t2_w       = $signed(sf_t2_r[i]);
      u_w        = $signed(sf_tag_r.u[i]);
      jac_nxt[i] = sf_tag_r.degen ? '0 : sat32(t1_w - t2_w - u_w);
    end
  end

  word_t                           out_residual_r;
  logic [NUM_AXES-1:0][WORD_W-1:0] out_jac_r;
  logic                            out_degenerate_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= sf_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_residual_r   <= res_nxt;
      out_jac_r        <= jac_nxt;
      out_degenerate_r <= sf_tag_r.degen;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_residual   = out_residual_r;
  assign out_jac_cx     = out_jac_r[0];
  assign out_jac_cy     = out_jac_r[1];
  assign out_jac_cz     = out_jac_r[2];
  assign out_degenerate = out_degenerate_r;

  // ---------------- assertions ----------------
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_degenerate_r |->
      out_residual_r == '0 && out_jac_r[0] == '0 && out_jac_r[1] == '0 &&
      out_jac_r[2] == '0)
    else $error("degenerate result with nonzero outputs");

  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(sf_v_r) && $stable(sb_v_r) && $stable(s1_v_r))
    else $error("pipeline moved during a stall");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !s1_v_r && !sf_v_r)
    else $error("valid bits not cleared by reset");

endmodule
`default_nettype wire
